>>> src/srs_pkg.sv
`default_nettype none

package srs_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int REQ_BITS        = 1;
    localparam int LOAD_INDEX_BITS = 10;
    localparam int ITEM_BITS       = 32;
    localparam int POS_BITS        = 11;
    localparam int COUNT_BITS      = 11;

    // Stream packing
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 24;

    // Configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Memory address source for the two read ports
    typedef enum logic [1:0] {
        ADDR_ENDS     = 2'd0,
        ADDR_MID_INIT = 2'd1,
        ADDR_MID_NEXT = 2'd2,
        ADDR_VERIFY   = 2'd3
    } t_addr_sel;

    typedef struct packed {
        logic      latch;
        logic      write;
        t_addr_sel addr_sel;
        logic      init_search;
        logic      step_search;
        logic      set_miss;
        logic      set_result;
        logic      push;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic in_range;
        logic search_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/sorted_range_search.sv
// Channel    Dir  Beat contents
// s_axis     in   tuser: req_type; tdata: load_index [9:0], item_value [41:10]
// m_axis     out  tdata: first_pos [10:0], last_pos [21:11]
// apb        in   element_count at byte address 0
//
// A load beat writes the store at the accepting edge.
// A query on an empty store or with the target outside the ends is answered as a miss with no
// search; any other query runs both bound searches, which share the dual-read store and
// advance one probe per cycle.
// Reset clears the element count, the controller and the output beat; the store
// keeps its contents. A new beat is accepted while a result waits on m_axis; the next
// query then holds in its last cycle until m_axis takes the waiting beat.
`default_nettype none

module sorted_range_search import srs_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // load_index, item_value
    input  wire logic [REQ_BITS-1:0]      s_axis_tuser,   // req_type
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,   // first_pos, last_pos
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_BITS-1:0]    paddr,
    input  wire logic [PDATA_BITS-1:0]    pwdata,
    output logic [PDATA_BITS-1:0]         prdata,
    output logic                          pready
);

    logic [COUNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0]   w_count_n;
    logic                  w_cfg_wr;
    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic [POS_BITS-1:0]   w_first_pos;
    logic [POS_BITS-1:0]   w_last_pos;

    // Register write and read back
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == REG_ELEMENT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_cfg_wr) begin
            r_count <= pwdata[COUNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? PDATA_BITS'(r_count) : '0;

    // Clamp the count to the store depth
    always_comb begin
        if (32'(r_count) > STORE_DEPTH) begin
            w_count_n = CNT_BITS'(STORE_DEPTH);
        end else begin
            w_count_n = CNT_BITS'(r_count);
        end
    end

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_query (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_count      (w_count_n),
        .i_load_index (s_axis_tdata[LOAD_INDEX_BITS-1:0]),
        .i_item_value (s_axis_tdata[LOAD_INDEX_BITS+ITEM_BITS-1:LOAD_INDEX_BITS]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_first_pos  (w_first_pos),
        .o_last_pos   (w_last_pos)
    );

    assign m_axis_tdata = {(OUT_DATA_BITS - 2 * POS_BITS)'(0), w_last_pos, w_first_pos};

endmodule

`default_nettype wire

>>> src/srs_ctrl.sv
`default_nettype none

module srs_ctrl import srs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_query,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RANGE  = 5'b00010,
        S_SEARCH = 5'b00100,
        S_VERIFY = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Write loads while idle; sequence one query: range check, both searches, verify, hand off
    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.latch       = 1'b0;
        o_cmd.write       = 1'b0;
        o_cmd.addr_sel    = ADDR_ENDS;
        o_cmd.init_search = 1'b0;
        o_cmd.step_search = 1'b0;
        o_cmd.set_miss    = 1'b0;
        o_cmd.set_result  = 1'b0;
        o_cmd.push        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_query == REQ_QUERY) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_RANGE;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_RANGE: begin
                if (i_stat.empty || !i_stat.in_range) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.init_search = 1'b1;
                    o_cmd.addr_sel    = ADDR_MID_INIT;
                    n_state           = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    o_cmd.addr_sel = ADDR_VERIFY;
                    n_state        = S_VERIFY;
                end else begin
                    o_cmd.step_search = 1'b1;
                    o_cmd.addr_sel    = ADDR_MID_NEXT;
                end
            end
            S_VERIFY: begin
                o_cmd.set_result = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> src/srs_datapath.sv
`default_nettype none

module srs_datapath import srs_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic [CNT_BITS-1:0]        i_count,
    input  wire logic [LOAD_INDEX_BITS-1:0] i_load_index,
    input  wire logic [ITEM_BITS-1:0]       i_item_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [POS_BITS-1:0]             o_first_pos,
    output logic [POS_BITS-1:0]             o_last_pos
);

    // Map a value to an unsigned key that keeps signed order
    function automatic logic [VALUE_BITS-1:0] to_key(input logic [ITEM_BITS-1:0] v);
        logic [VALUE_BITS-1:0] k;
        k = VALUE_BITS'(v);
        k[VALUE_BITS-1] = ~k[VALUE_BITS-1];
        return k;
    endfunction

    function automatic logic [CNT_BITS-1:0] mid_of(input logic [CNT_BITS-1:0] lo,
                                                   input logic [CNT_BITS-1:0] hi);
        logic [CNT_BITS:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[CNT_BITS:1];
    endfunction

    logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
    logic [VALUE_BITS-1:0] r_rd_a;
    logic [VALUE_BITS-1:0] r_rd_b;
    logic [IDX_BITS-1:0]   w_addr_a;
    logic [IDX_BITS-1:0]   w_addr_b;
    logic                  w_load_ok;

    logic [VALUE_BITS-1:0] r_key;
    logic [CNT_BITS-1:0]   r_n;
    logic [CNT_BITS-1:0]   r_lo_a, r_hi_a, r_lo_b, r_hi_b;
    logic [CNT_BITS-1:0]   n_lo_a, n_hi_a, n_lo_b, n_hi_b;
    logic [CNT_BITS-1:0]   w_mid_a, w_mid_b;
    logic [CNT_BITS-1:0]   w_last_b;
    logic [POS_BITS-1:0]   r_first, r_last;
    logic                  w_has_first, w_has_last;

    logic                  r_out_valid;
    logic [POS_BITS-1:0]   r_out_first, r_out_last;

    // Next bounds: lower bound on port A, upper bound on port B
    always_comb begin
        w_mid_a = mid_of(r_lo_a, r_hi_a);
        w_mid_b = mid_of(r_lo_b, r_hi_b);
        n_lo_a  = r_lo_a;
        n_hi_a  = r_hi_a;
        n_lo_b  = r_lo_b;
        n_hi_b  = r_hi_b;
        if (r_lo_a < r_hi_a) begin
            if (r_rd_a < r_key) begin
                n_lo_a = w_mid_a + CNT_BITS'(1);
            end else begin
                n_hi_a = w_mid_a;
            end
        end
        if (r_lo_b < r_hi_b) begin
            if (r_rd_b <= r_key) begin
                n_lo_b = w_mid_b + CNT_BITS'(1);
            end else begin
                n_hi_b = w_mid_b;
            end
        end
    end

    assign w_last_b = r_hi_b - CNT_BITS'(1);

    // Select read addresses for both ports
    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_ENDS: begin
                w_addr_a = '0;
                w_addr_b = IDX_BITS'(i_count - CNT_BITS'(1));
            end
            ADDR_MID_INIT: begin
                w_addr_a = IDX_BITS'(r_n >> 1);
                w_addr_b = IDX_BITS'(r_n >> 1);
            end
            ADDR_MID_NEXT: begin
                w_addr_a = IDX_BITS'(mid_of(n_lo_a, n_hi_a));
                w_addr_b = IDX_BITS'(mid_of(n_lo_b, n_hi_b));
            end
            default: begin
                w_addr_a = IDX_BITS'(r_lo_a);
                w_addr_b = IDX_BITS'(w_last_b);
            end
        endcase
    end

    // Store: one write port, two registered read ports
    assign w_load_ok = 32'(i_load_index) < STORE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_load_ok) begin
            mem[IDX_BITS'(i_load_index)] <= to_key(i_item_value);
        end
        r_rd_a <= mem[w_addr_a];
        r_rd_b <= mem[w_addr_b];
    end

    assign w_has_first = (r_lo_a < r_n) && (r_rd_a == r_key);
    assign w_has_last  = (r_hi_b != '0) && (r_rd_b == r_key);

    // Hold target, bounds and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key <= to_key(i_item_value);
            r_n   <= i_count;
        end
        if (i_cmd.init_search) begin
            r_lo_a <= '0;
            r_hi_a <= r_n;
            r_lo_b <= '0;
            r_hi_b <= r_n;
        end else if (i_cmd.step_search) begin
            r_lo_a <= n_lo_a;
            r_hi_a <= n_hi_a;
            r_lo_b <= n_lo_b;
            r_hi_b <= n_hi_b;
        end
        if (i_cmd.set_miss) begin
            r_first <= '1;
            r_last  <= '1;
        end else if (i_cmd.set_result) begin
            if (w_has_first && w_has_last) begin
                r_first <= POS_BITS'(r_lo_a);
                r_last  <= POS_BITS'(w_last_b);
            end else begin
                r_first <= '1;
                r_last  <= '1;
            end
        end
        if (i_cmd.push) begin
            r_out_first <= r_first;
            r_out_last  <= r_last;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.empty       = (r_n == '0);
    assign o_stat.in_range    = (r_rd_a <= r_key) && (r_key <= r_rd_b);
    assign o_stat.search_done = (r_lo_a == r_hi_a) && (r_lo_b == r_hi_b);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_first_pos = r_out_first;
    assign o_last_pos  = r_out_last;

endmodule

`default_nettype wire

>>> dv/sorted_range_search_checker.sv
module sorted_range_search_checker import srs_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_tvalid,
    input  wire logic                     i_in_tready,
    input  wire logic [IN_DATA_BITS-1:0]  i_in_tdata,   // load_index, item_value
    input  wire logic [REQ_BITS-1:0]      i_in_tuser,   // req_type
    input  wire logic                     i_out_tvalid,
    input  wire logic                     i_out_tready,
    input  wire logic [OUT_DATA_BITS-1:0] i_out_tdata,  // first_pos, last_pos
    input  wire logic                     i_psel,
    input  wire logic                     i_penable,
    input  wire logic                     i_pwrite,
    input  wire logic [PADDR_BITS-1:0]    i_paddr,
    input  wire logic [PDATA_BITS-1:0]    i_pwdata,
    input  wire logic                     i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int VALUE_LSB = LOAD_INDEX_BITS;
    localparam int LAST_LSB  = POS_BITS;
    localparam logic [POS_BITS-1:0]   NOT_FOUND_POS = '1;
    localparam logic [PADDR_BITS-1:0] COUNT_ADDR    = PADDR_BITS'(4 * REG_ELEMENT_COUNT);

    typedef struct packed {
        logic [POS_BITS-1:0] first_pos;
        logic [POS_BITS-1:0] last_pos;
    } pos_pair_t;

    logic signed [ITEM_BITS-1:0] store_vals [STORE_DEPTH];
    logic [COUNT_BITS-1:0]       elem_count;
    pos_pair_t                   range_q [$];
    int                          fails;

    initial begin
        foreach (store_vals[i]) store_vals[i] = '0;
        elem_count   = '0;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // First index in [0,n) whose value is not below the target, or above it; n if there is none
    function automatic int unsigned bound_of(int unsigned n, logic signed [ITEM_BITS-1:0] target,
                                             bit past_equal);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic signed [ITEM_BITS-1:0] v;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            v   = store_vals[mid];
            if (past_equal ? (v <= target) : (v < target)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Work out the first and last position of a target in the entries in use
    function automatic pos_pair_t locate_range(logic signed [ITEM_BITS-1:0] target);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        pos_pair_t   res;
        res.first_pos = NOT_FOUND_POS;
        res.last_pos  = NOT_FOUND_POS;
        n = (elem_count > STORE_DEPTH) ? STORE_DEPTH : elem_count;
        if (n == 0) return res;
        if (target < store_vals[0] || target > store_vals[n-1]) return res;
        lo = bound_of(n, target, 1'b0);
        hi = bound_of(n, target, 1'b1);
        if (lo < n && hi > 0) begin
            if (store_vals[lo] == target && store_vals[hi-1] == target) begin
                res.first_pos = POS_BITS'(lo);
                res.last_pos  = POS_BITS'(hi - 1);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        pos_pair_t                   want;
        logic [POS_BITS-1:0]         got_first;
        logic [POS_BITS-1:0]         got_last;
        logic [LOAD_INDEX_BITS-1:0]  idx;
        logic signed [ITEM_BITS-1:0] value;
        if (!i_rst_n) begin
            elem_count = '0;
        end else begin
            // Compare a result beat with the oldest prediction
            if (i_out_tvalid && i_out_tready) begin
                got_first = i_out_tdata[POS_BITS-1:0];
                got_last  = i_out_tdata[LAST_LSB +: POS_BITS];
                if (range_q.size() == 0) begin
                    $error("unexpected result beat: first_pos %0d, last_pos %0d",
                           $signed(got_first), $signed(got_last));
                    fails++;
                end else begin
                    want = range_q.pop_front();
                    if (got_first !== want.first_pos) begin
                        $error("first_pos: expected %0d, got %0d",
                               $signed(want.first_pos), $signed(got_first));
                        fails++;
                    end
                    if (got_last !== want.last_pos) begin
                        $error("last_pos: expected %0d, got %0d",
                               $signed(want.last_pos), $signed(got_last));
                        fails++;
                    end
                end
            end
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == COUNT_ADDR) begin
                elem_count = i_pwdata[COUNT_BITS-1:0];
            end
            // Apply a load or predict a query
            if (i_in_tvalid && i_in_tready) begin
                idx   = i_in_tdata[LOAD_INDEX_BITS-1:0];
                value = i_in_tdata[VALUE_LSB +: ITEM_BITS];
                if (i_in_tuser == REQ_LOAD) begin
                    store_vals[idx] = value;
                end else begin
                    range_q.push_back(locate_range(value));
                end
            end
        end
        o_pending    <= range_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> dv/sorted_range_search_test.sv
module sorted_range_search_test;

    import srs_pkg::*;

    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int RUN_LIMIT      = 2000000;
    localparam logic [PADDR_BITS-1:0] COUNT_ADDR = PADDR_BITS'(4 * REG_ELEMENT_COUNT);

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // load_index, item_value
    logic [REQ_BITS-1:0]      s_axis_tuser;   // req_type
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // first_pos, last_pos
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_BITS-1:0]    paddr;
    logic [PDATA_BITS-1:0]    pwdata;
    logic [PDATA_BITS-1:0]    prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending;

    // Stimulus controls shared with the receiver
    bit steady    = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    // Values loaded so far, used only to aim query targets
    int vals [STORE_DEPTH];

    sorted_range_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sorted_range_search_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #RUN_LIMIT;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result receiver: random stalls, one long hold-off, steady stretches
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 29);
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [REQ_BITS-1:0] kind,
                             input logic [LOAD_INDEX_BITS-1:0] idx,
                             input logic [ITEM_BITS-1:0] value);
        while (!steady && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_DATA_BITS - LOAD_INDEX_BITS - ITEM_BITS){1'b0}}, value, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_entry(input int unsigned idx, input int value);
        vals[idx] = value;
        send_beat(REQ_LOAD, LOAD_INDEX_BITS'(idx), value);
    endtask

    task automatic query_value(input int target);
        send_beat(REQ_QUERY, LOAD_INDEX_BITS'($urandom), target);
    endtask

    task automatic write_count(input logic [PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, wait for every result, then let the block go quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Load entries 0..n-1 with a non-decreasing run, in rotated index order
    task automatic load_sorted(input int unsigned n, input longint start,
                               input int unsigned max_step);
        longint      cur;
        int unsigned first_idx;
        int unsigned k;
        int          run [STORE_DEPTH];
        cur = start;
        for (k = 0; k < n; k++) begin
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            run[k] = int'(cur);
            if ($urandom_range(99) >= 30) cur += longint'($urandom_range(max_step, 1));
        end
        first_idx = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
            load_entry((first_idx + k) % n, run[(first_idx + k) % n]);
        end
    endtask

    // Aim mostly at stored values, their neighbors, the ends and the extremes
    function automatic int pick_target(input int unsigned n);
        int unsigned r;
        int          v;
        r = $urandom_range(99);
        if (n == 0) return int'($urandom);
        v = vals[$urandom_range(n - 1)];
        if (r < 55) return v;
        if (r < 70) return $urandom_range(1) ? v + 1 : v - 1;
        if (r < 76) return vals[0] - 1;
        if (r < 82) return vals[n-1] + 1;
        if (r < 88) return 32'sh8000_0000;
        if (r < 94) return 32'sh7FFF_FFFF;
        return int'($urandom);
    endfunction

    initial begin : stimulus
        int unsigned n;
        int unsigned q;
        int unsigned k;
        int unsigned r;
        int          random_items;
        int          phase_no;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_LOAD;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store right after reset
        query_value(5);

        // Small sorted set with duplicates
        load_entry(0, -100);
        load_entry(1, -7);
        load_entry(2, -7);
        load_entry(3, 3);
        load_entry(4, 40);
        drain_results();
        write_count(5);
        query_value(-101);
        query_value(41);
        query_value(-100);
        query_value(40);
        query_value(-7);
        query_value(0);
        query_value(3);
        query_value(32'sh8000_0000);
        query_value(32'sh7FFF_FFFF);

        // Value extremes at both ends
        load_entry(0, 32'sh8000_0000);
        load_entry(4, 32'sh7FFF_FFFF);
        query_value(32'sh8000_0000);
        query_value(32'sh7FFF_FFFF);

        // Break the order in the middle
        load_entry(2, 50);
        query_value(50);
        query_value(-7);

        // Single entry in use
        drain_results();
        write_count(1);
        query_value(32'sh8000_0000);

        // Fill the whole store across the full value range
        load_sorted(STORE_DEPTH, 64'sh8000_0000 - 64'sh1_0000_0000, 1 << 23);
        drain_results();
        write_count(STORE_DEPTH);
        for (q = 0; q < 20; q++) query_value(pick_target(STORE_DEPTH));
        drain_results();

        // Count beyond the depth acts as the full depth
        write_count((1 << COUNT_BITS) - 1);
        for (q = 0; q < 10; q++) query_value(pick_target(STORE_DEPTH));
        drain_results();

        // Random phases: new count, a sorted run, then queries with some noise
        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            n = (r < 8) ? 0 : (r < 88) ? $urandom_range(24, 1) : $urandom_range(200, 25);
            if (phase_no == 3) begin
                n        = 6;
                hold_req = 1'b1;
            end
            steady = (phase_no == 5);
            write_count(n);
            if (n > 0 && $urandom_range(99) < 85) begin
                load_sorted(n, longint'($signed($urandom)),
                            $urandom_range(1) ? 4 : (1 << 16));
                random_items += n;
            end
            q = $urandom_range(24, 8);
            for (k = 0; k < q; k++) begin
                if ($urandom_range(99) < 8) begin
                    load_entry($urandom_range(STORE_DEPTH - 1), int'($urandom));
                end else begin
                    query_value(pick_target(n));
                end
            end
            random_items += q;
            drain_results();
            steady = 1'b0;
            phase_no++;
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
